/* sv/bots_pkg.sv */
// Shared types and constants for the bulk-only transport sequencer.
// Holds the item and result structs and the action, error and USB result codes.
// No dependencies.
package bots_pkg;

    // Transfer sizes
    localparam int PACKET_BYTES  = 64;
    localparam int COMMAND_BYTES = 31;
    localparam int STATUS_BYTES  = 13;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 16;
    localparam int REM_W   = 17;
    localparam int COUNT_W = 7;

    localparam logic [COUNT_W-1:0] PACKET_CNT  = COUNT_W'(PACKET_BYTES);
    localparam logic [COUNT_W-1:0] COMMAND_CNT = COUNT_W'(COMMAND_BYTES);
    localparam logic [COUNT_W-1:0] STATUS_CNT  = COUNT_W'(STATUS_BYTES);
    localparam logic [REM_W-1:0]   PACKET_REM  = REM_W'(PACKET_BYTES);
    localparam logic [ADDR_W-1:0]  PACKET_INC  = ADDR_W'(PACKET_BYTES);

    // 'USBS' with byte 0 in the low bits
    localparam logic [31:0] STATUS_MAGIC = 32'h5342_5355;

    // Operation codes (input kind)
    localparam logic OP_START  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // USB transaction report codes
    localparam logic [1:0] USB_OK        = 2'd0;
    localparam logic [1:0] USB_BUSY      = 2'd1;
    localparam logic [1:0] USB_ERROR     = 2'd2;
    localparam logic [1:0] USB_NOT_SETUP = 2'd3;

    // Action codes
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_SEND_CMD    = 3'd1;
    localparam logic [2:0] ACT_RECV_DATA   = 3'd2;
    localparam logic [2:0] ACT_SEND_DATA   = 3'd3;
    localparam logic [2:0] ACT_RECV_STATUS = 3'd4;
    localparam logic [2:0] ACT_DONE_OK     = 3'd5;
    localparam logic [2:0] ACT_DONE_ERR    = 3'd6;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SIZE      = 3'd1;
    localparam logic [2:0] ERR_SIGNATURE = 3'd2;
    localparam logic [2:0] ERR_DEVICE    = 3'd3;
    localparam logic [2:0] ERR_NOT_SETUP = 3'd4;

    typedef struct packed {
        logic               operation;
        logic               is_write;
        logic [LEN_W-1:0]   data_length;
        logic [ADDR_W-1:0]  buffer_address;
        logic [1:0]         usb_result;
        logic [COUNT_W-1:0] byte_count;
        logic [31:0]        status_signature;
        logic [7:0]         status_code;
    } item_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [ADDR_W-1:0]  transfer_address;
        logic [COUNT_W-1:0] transfer_count;
        logic [2:0]         error_code;
        logic               busy_res;
    } result_t;

    // Input register status toward the top level
    typedef struct packed {
        logic  valid;
        item_t item;
    } in_stage_t;

endpackage

/* sv/bots_in_reg.sv */
// Input register of the bulk-only transport sequencer.
// Captures one incoming transfer and holds it until the sequencer takes it.
// Depends on bots_pkg.
module bots_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bots_pkg::item_t     in_item,
    input  logic                take,
    output bots_pkg::in_stage_t stage
);

    logic            valid_reg;
    logic            valid_next;
    bots_pkg::item_t item_reg;

    // Free slot, or the held item leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

/* sv/bots_seq.sv */
// Phase sequencer of the bulk-only transport sequencer.
// Holds the command state and computes the result of one item combinationally.
// Depends on bots_pkg.
module bots_seq
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [bots_pkg::ADDR_W-1:0]      cmd_buf_addr,
    input  logic                             step,
    input  bots_pkg::item_t                  item,
    output bots_pkg::result_t                res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMD,
        PH_DATA,
        PH_STATUS
    } phase_t;

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic [bots_pkg::REM_W-1:0]      remaining_reg;
    logic [bots_pkg::REM_W-1:0]      remaining_next;
    logic [bots_pkg::ADDR_W-1:0]     cur_addr_reg;
    logic [bots_pkg::ADDR_W-1:0]     cur_addr_next;
    logic                            write_dir_reg;
    logic                            write_dir_next;
    logic [2:0]                      last_err_reg;
    logic [2:0]                      last_err_next;
    logic [2:0]                      action;
    logic [bots_pkg::ADDR_W-1:0]     taddr;
    logic [bots_pkg::COUNT_W-1:0]    tcnt;
    logic [2:0]                      data_act;
    logic [2:0]                      status_err;
    logic [bots_pkg::ADDR_W-1:0]     addr_inc;

    assign data_act = write_dir_reg ? bots_pkg::ACT_SEND_DATA : bots_pkg::ACT_RECV_DATA;
    assign addr_inc = cur_addr_reg + bots_pkg::PACKET_INC;

    // Status block check, first failing test wins
    always_comb
    begin
        if (item.byte_count != bots_pkg::STATUS_CNT)
            status_err = bots_pkg::ERR_SIZE;
        else if (item.status_signature != bots_pkg::STATUS_MAGIC)
            status_err = bots_pkg::ERR_SIGNATURE;
        else if (item.status_code != 8'd0)
            status_err = bots_pkg::ERR_DEVICE;
        else
            status_err = bots_pkg::ERR_NONE;
    end

    // Next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        cur_addr_next  = cur_addr_reg;
        write_dir_next = write_dir_reg;
        last_err_next  = last_err_reg;
        action         = bots_pkg::ACT_NONE;
        taddr          = '0;
        tcnt           = '0;

        if (item.operation == bots_pkg::OP_START)
        begin
            // Start while busy is ignored
            if (phase_reg == PH_IDLE)
            begin
                remaining_next = bots_pkg::REM_W'(item.data_length);
                cur_addr_next  = item.buffer_address;
                write_dir_next = item.is_write;
                last_err_next  = bots_pkg::ERR_NONE;
                phase_next     = PH_CMD;
                action         = bots_pkg::ACT_SEND_CMD;
                taddr          = cmd_buf_addr;
                tcnt           = bots_pkg::COMMAND_CNT;
            end
        end
        else if (phase_reg != PH_IDLE && item.usb_result != bots_pkg::USB_BUSY)
        begin
            if (item.usb_result == bots_pkg::USB_ERROR)
            begin
                last_err_next = bots_pkg::ERR_DEVICE;
                phase_next    = PH_IDLE;
                action        = bots_pkg::ACT_DONE_ERR;
            end
            else if (item.usb_result == bots_pkg::USB_NOT_SETUP)
            begin
                last_err_next = bots_pkg::ERR_NOT_SETUP;
                phase_next    = PH_IDLE;
                action        = bots_pkg::ACT_DONE_ERR;
            end
            else
            begin
                case (phase_reg)
                    PH_CMD:
                    begin
                        phase_next = PH_DATA;
                        action     = data_act;
                        taddr      = cur_addr_reg;
                        tcnt       = bots_pkg::PACKET_CNT;
                    end
                    PH_DATA:
                    begin
                        if (remaining_reg > bots_pkg::PACKET_REM)
                        begin
                            remaining_next = remaining_reg - bots_pkg::PACKET_REM;
                            cur_addr_next  = addr_inc;
                            action         = data_act;
                            taddr          = addr_inc;
                            tcnt           = bots_pkg::PACKET_CNT;
                        end
                        else
                        begin
                            remaining_next = '0;
                            phase_next     = PH_STATUS;
                            action         = bots_pkg::ACT_RECV_STATUS;
                            taddr          = cmd_buf_addr;
                            tcnt           = bots_pkg::STATUS_CNT;
                        end
                    end
                    PH_STATUS:
                    begin
                        last_err_next = status_err;
                        phase_next    = PH_IDLE;
                        action        = (status_err != bots_pkg::ERR_NONE) ?
                                        bots_pkg::ACT_DONE_ERR : bots_pkg::ACT_DONE_OK;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign res.action           = action;
    assign res.transfer_address = taddr;
    assign res.transfer_count   = tcnt;
    assign res.error_code       = last_err_next;
    assign res.busy_res         = (phase_next != PH_IDLE);

    // Command state, updated when an item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= '0;
            cur_addr_reg  <= '0;
            write_dir_reg <= 1'b0;
            last_err_reg  <= bots_pkg::ERR_NONE;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            cur_addr_reg  <= cur_addr_next;
            write_dir_reg <= write_dir_next;
            last_err_reg  <= last_err_next;
        end
    end

    // Start during a command leaves the state alone
    a_start_busy_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.operation == bots_pkg::OP_START && phase_reg != PH_IDLE
        |=> $stable(phase_reg) && $stable(cur_addr_reg) && $stable(remaining_reg))
        else $error("start while busy changed the command state");

    // A finished command returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && (action == bots_pkg::ACT_DONE_OK || action == bots_pkg::ACT_DONE_ERR)
        |=> phase_reg == PH_IDLE)
        else $error("command finished but phase not idle");

    // A new command starts with a clean error
    a_start_clears_err: assert property (@(posedge clk) disable iff (!rst_n)
        step && action == bots_pkg::ACT_SEND_CMD |=> last_err_reg == bots_pkg::ERR_NONE)
        else $error("command start did not clear the error");

    // Data packets only go out in the data phase or right after the command
    a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step && (action == bots_pkg::ACT_SEND_DATA || action == bots_pkg::ACT_RECV_DATA)
        |=> phase_reg == PH_DATA)
        else $error("data transfer issued outside the data phase");

endmodule

/* sv/bulk_only_transport_sequencer.sv */
// Top level of the bulk-only transport sequencer: stream ports, configuration
// register, input register, phase sequencer and result register.
// Depends on bots_pkg, bots_in_reg and bots_seq.
// An accepted input transfer reaches its result on the master side through the input
// register, then the result register. Throughput: one item per clock while m_tready
// does not stall the result register, as the sequencer updates its state once per item.
// Reset (rst_n, asynchronous, active low) empties both registers, returns the
// phase to idle and clears the command buffer address and all command state to zero.
module bulk_only_transport_sequencer
(
    input  logic         clk,
    input  logic         rst_n,
    // Configuration: command_buffer_address
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] is_write, [16:1] data_length, [48:17] buffer_address, [50:49] usb_result,
    // [57:51] byte_count, [89:58] status_signature, [97:90] status_code, [103:98] zero
    input  logic [103:0] s_tdata,
    // [0] operation
    input  logic         s_tuser,
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] transfer_address, [38:32] transfer_count, [41:39] error_code,
    // [42] busy_res, [47:43] zero
    output logic [47:0]  m_tdata,
    // [2:0] action
    output logic [2:0]   m_tuser
);

    logic [31:0]         cmd_buf_addr_reg;
    bots_pkg::item_t     in_item;
    bots_pkg::in_stage_t stage;
    bots_pkg::result_t   seq_res;
    bots_pkg::result_t   res_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                take;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_buf_addr_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            cmd_buf_addr_reg <= cfg_wr_data;
        end
    end

    // Unpack the input transfer
    assign in_item.operation        = s_tuser;
    assign in_item.is_write         = s_tdata[0];
    assign in_item.data_length      = s_tdata[16:1];
    assign in_item.buffer_address   = s_tdata[48:17];
    assign in_item.usb_result       = s_tdata[50:49];
    assign in_item.byte_count       = s_tdata[57:51];
    assign in_item.status_signature = s_tdata[89:58];
    assign in_item.status_code      = s_tdata[97:90];

    bots_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .take     (take),
        .stage    (stage)
    );

    // Held item moves on when the result register is free or draining
    assign take = stage.valid && (!out_valid_reg || m_tready);

    bots_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_buf_addr (cmd_buf_addr_reg),
        .step         (take),
        .item         (stage.item),
        .res          (seq_res)
    );

    assign out_valid_next = take || (out_valid_reg && !m_tready);

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= seq_res;
        end
    end

    // Pack the result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.action;
    assign m_tdata  = {5'd0, res_reg.busy_res, res_reg.error_code,
                       res_reg.transfer_count, res_reg.transfer_address};

endmodule
